// ===== hw/rtl/utf8d_pkg.sv =====
// Shared types and constants for the UTF-8 validating decoder.
package utf8d_pkg;

	localparam int unsigned CU_W = 21;

	localparam logic [7:0] ASCII_MAX  = 8'h7F;
	localparam logic [7:0] LEAD2_LO   = 8'hC2;
	localparam logic [7:0] LEAD2_HI   = 8'hDF;
	localparam logic [7:0] LEAD3_LO   = 8'hE0;
	localparam logic [7:0] LEAD3_SURR = 8'hED;
	localparam logic [7:0] LEAD3_HI   = 8'hEF;
	localparam logic [7:0] LEAD4_LO   = 8'hF0;
	localparam logic [7:0] LEAD4_HI   = 8'hF4;

	localparam logic [7:0] BOUND_LO    = 8'h80;
	localparam logic [7:0] BOUND_HI    = 8'hBF;
	localparam logic [7:0] E0_BOUND_LO = 8'hA0;
	localparam logic [7:0] ED_BOUND_HI = 8'h9F;
	localparam logic [7:0] F0_BOUND_LO = 8'h90;
	localparam logic [7:0] F4_BOUND_HI = 8'h8F;

	localparam logic [CU_W-1:0] SUPP_BASE = 21'h010000;
	localparam logic [CU_W-1:0] HI_SURR   = 21'h00D800;
	localparam logic [CU_W-1:0] LO_SURR   = 21'h00DC00;

	localparam logic OUT_UTF32 = 1'b0;

	// Output queue depth: one beat waiting plus room for a surrogate pair.
	localparam int unsigned OQ_DEPTH = 3;
	localparam int unsigned OQ_CW    = $clog2(OQ_DEPTH + 1);

	typedef struct packed {
		logic [CU_W-1:0] pv;
		logic [1:0]      rem;
		logic [7:0]      lo;
		logic [7:0]      hi;
	} dec_state_t;

	localparam dec_state_t STATE_RESET = '{pv: '0, rem: 2'd0, lo: BOUND_LO, hi: BOUND_HI};

	typedef struct packed {
		logic [CU_W-1:0] code_unit;
		logic            malformed;
		logic            last;
	} result_t;

	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} step_out_t;

endpackage

// ===== hw/rtl/utf8d_step.sv =====
// One-byte decode step: range checks, value accumulation, UTF-16 split.
module utf8d_step (
	input  utf8d_pkg::dec_state_t st,
	input  logic [7:0]            in_byte,
	input  logic                  end_of_text,
	input  logic                  output_form,
	output utf8d_pkg::dec_state_t nxt,
	output utf8d_pkg::step_out_t  res
);
	import utf8d_pkg::*;

	logic            fail;
	logic            done;
	logic [CU_W-1:0] sv;
	logic [19:0]     v;

	always_comb begin
		nxt  = st;
		fail = 1'b0;
		done = 1'b0;
		sv   = '0;
		res  = '0;
		if (st.rem == 2'd0) begin
			nxt.lo = BOUND_LO;
			nxt.hi = BOUND_HI;
			unique case (in_byte) inside
				[8'h00:ASCII_MAX]: begin
					done = 1'b1;
					sv   = CU_W'(in_byte);
				end
				[LEAD2_LO:LEAD2_HI]: begin
					nxt.pv  = CU_W'(in_byte[4:0]);
					nxt.rem = 2'd1;
				end
				[LEAD3_LO:LEAD3_HI]: begin
					nxt.pv  = CU_W'(in_byte[3:0]);
					nxt.rem = 2'd2;
					if (in_byte == LEAD3_LO)
						nxt.lo = E0_BOUND_LO;
					else if (in_byte == LEAD3_SURR)
						nxt.hi = ED_BOUND_HI;
				end
				[LEAD4_LO:LEAD4_HI]: begin
					nxt.pv  = CU_W'(in_byte[2:0]);
					nxt.rem = 2'd3;
					if (in_byte == LEAD4_LO)
						nxt.lo = F0_BOUND_LO;
					else if (in_byte == LEAD4_HI)
						nxt.hi = F4_BOUND_HI;
				end
				default: fail = 1'b1;
			endcase
			// lead byte on the final beat leaves the sequence cut off
			if (!done && !fail && end_of_text)
				fail = 1'b1;
		end else begin
			if (in_byte < st.lo || in_byte > st.hi) begin
				fail = 1'b1;
			end else begin
				nxt.pv  = {st.pv[CU_W-7:0], in_byte[5:0]};
				nxt.rem = st.rem - 2'd1;
				nxt.lo  = BOUND_LO;
				nxt.hi  = BOUND_HI;
				if (nxt.rem == 2'd0) begin
					done = 1'b1;
					sv   = nxt.pv;
				end else if (end_of_text) begin
					fail = 1'b1;
				end
			end
		end

		if (fail || done)
			nxt = STATE_RESET;

		v = 20'(sv - SUPP_BASE);

		if (fail) begin
			res.n  = 2'd1;
			res.r0 = '{code_unit: '0, malformed: 1'b1, last: 1'b1};
		end else if (done) begin
			if (output_form == OUT_UTF32 || sv < SUPP_BASE) begin
				res.n  = 2'd1;
				res.r0 = '{code_unit: sv, malformed: 1'b0, last: 1'b1};
			end else begin
				res.n  = 2'd2;
				res.r0 = '{code_unit: HI_SURR + CU_W'(v[19:10]), malformed: 1'b0,
					last: 1'b0};
				res.r1 = '{code_unit: LO_SURR + CU_W'(v[9:0]), malformed: 1'b0,
					last: 1'b1};
			end
		end
	end

endmodule

// ===== hw/rtl/utf8d_oq.sv =====
// Small shifting result queue in front of the master-side stream.
module utf8d_oq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  utf8d_pkg::step_out_t push_res,
	output logic                 space,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output utf8d_pkg::result_t   head
);
	import utf8d_pkg::*;

	result_t            q_q [OQ_DEPTH];
	result_t            q_d [OQ_DEPTH];
	logic [OQ_CW-1:0]   cnt_q;
	logic [OQ_CW-1:0]   cnt_after;
	logic [OQ_CW-1:0]   cnt_d;
	logic [OQ_CW-1:0]   n_push;
	logic               pop;

	assign pop       = (cnt_q != '0) && m_tready;
	assign cnt_after = cnt_q - OQ_CW'(pop);
	// a step may push two beats
	assign space     = cnt_after <= OQ_CW'(OQ_DEPTH - 2);
	assign n_push    = push ? OQ_CW'(push_res.n) : '0;
	assign cnt_d     = cnt_after + n_push;
	assign m_tvalid  = cnt_q != '0;
	assign head      = q_q[0];

	always_comb begin
		for (int i = 0; i < OQ_DEPTH; i++) begin
			if (pop && i < OQ_DEPTH - 1)
				q_d[i] = q_q[i + 1];
			else
				q_d[i] = q_q[i];
			if (OQ_CW'(i) == cnt_after && n_push != '0)
				q_d[i] = push_res.r0;
			else if (OQ_CW'(i) == cnt_after + OQ_CW'(1) && n_push == OQ_CW'(2))
				q_d[i] = push_res.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else
			cnt_q <= cnt_d;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < OQ_DEPTH; i++)
			q_q[i] <= q_d[i];
	end

endmodule

// ===== hw/rtl/utf8_validating_decoder_top.sv =====
// Strict UTF-8 validating decoder, top level.
//
// Slave side: one text byte per beat in s_tdata, s_tlast marks the final byte
// of the text. Master side: m_tdata carries a UTF-32 scalar or a UTF-16 code
// unit, m_tuser flags a malformed or truncated sequence (data is zero then),
// m_tlast marks the final result beat caused by one input byte.
// cfg_we/cfg_wdata select the output form (0 UTF-32, 1 UTF-16); write it only
// while the decoder is idle.
// A result beat enters the registered result queue the cycle after the byte that
// completes the sequence. Throughput: one byte per cycle while s_tready is high;
// a surrogate pair takes two output beats out of a three-entry result queue, and
// s_tready stays high as long as the receiver takes a beat every cycle.
// Bytes that start or continue a sequence give no beat unless malformed or final.
// When the receiver stalls the queue fills; s_tready drops once fewer than
// two entries would be free, and no beat is lost or repeated.
// Reset clears the sequence state, the queue and selects UTF-32 output.
module utf8_validating_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] in_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [20:0] code_unit, [23:21] zero
	output logic        m_tuser,  // [0] malformed
	output logic        m_tlast
);
	import utf8d_pkg::*;

	dec_state_t st_q;
	dec_state_t st_d;
	step_out_t  step_res;
	result_t    head;
	logic       output_form_q;
	logic       s_acc;
	logic       space;

	assign s_tready = space;
	assign s_acc    = s_tvalid && space;

	utf8d_step u_step (
		.st          (st_q),
		.in_byte     (s_tdata),
		.end_of_text (s_tlast),
		.output_form (output_form_q),
		.nxt         (st_d),
		.res         (step_res)
	);

	utf8d_oq u_oq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (s_acc),
		.push_res (step_res),
		.space    (space),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.head     (head)
	);

	assign m_tdata = {3'b000, head.code_unit};
	assign m_tuser = head.malformed;
	assign m_tlast = head.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= STATE_RESET;
			output_form_q <= OUT_UTF32;
		end else begin
			if (s_acc)
				st_q <= st_d;
			if (cfg_we)
				output_form_q <= cfg_wdata;
		end
	end

	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && step_res.n != 2'd0 |=> m_tvalid)
		else $error("pushed result not presented");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 24'd0 && m_tlast)
		else $error("error beat carries data or is not last");

	a_idle_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.rem == 2'd0 |-> st_q.lo == BOUND_LO && st_q.hi == BOUND_HI
			&& st_q.pv == '0)
		else $error("stale sequence state while expecting a lead byte");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast)
		else $error("high surrogate not followed by its low half");

	a_utf32_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && output_form_q == OUT_UTF32 && $stable(output_form_q) |-> m_tlast)
		else $error("UTF-32 beat without last flag");

endmodule
